[hw/rtl/svr_pkg.sv]
package svr_pkg;

    // sample store geometry
    localparam int SAMPLE_DEPTH = 65536;
    localparam int SAMPLE_BITS  = 16;
    localparam int ADDR_BITS    = $clog2(SAMPLE_DEPTH);
    localparam int KEEP_BITS    = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
    localparam logic [15:0] SAMPLE_MASK = 16'(16'hFFFF << (16 - KEEP_BITS));

    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [3:0]           state_t;

    // operation codes
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_RENDER  = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // configuration register indexes
    localparam logic [3:0] CFG_INTERPOLATE = 4'd0;
    localparam logic [3:0] CFG_PITCH_STEP  = 4'd1;
    localparam logic [3:0] CFG_LENGTH      = 4'd2;
    localparam logic [3:0] CFG_GAIN_LEFT   = 4'd3;
    localparam logic [3:0] CFG_GAIN_RIGHT  = 4'd4;
    localparam logic [3:0] CFG_FILTER_EN   = 4'd5;
    localparam logic [3:0] CFG_CUTOFF      = 4'd6;
    localparam logic [3:0] CFG_RESONANCE   = 4'd7;

    // sequencer states
    localparam state_t S_IDLE   = 4'd0;
    localparam state_t S_FETCH0 = 4'd1;
    localparam state_t S_FETCH1 = 4'd2;
    localparam state_t S_INTERP = 4'd3;
    localparam state_t S_ENV    = 4'd4;
    localparam state_t S_ESC    = 4'd5;
    localparam state_t S_FA     = 4'd6;
    localparam state_t S_FB     = 4'd7;
    localparam state_t S_FC     = 4'd8;
    localparam state_t S_FD     = 4'd9;
    localparam state_t S_FE     = 4'd10;
    localparam state_t S_GAIN   = 4'd11;
    localparam state_t S_OUT    = 4'd12;

endpackage

[hw/rtl/svr_ram.sv]
module svr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/sample_voice_render_top.sv]
// channel   direction  handshake            beat contents
// in        to block   in_valid / in_stall  operation, address, sample_left/right, envelope
// out       from block out_valid / out_stall out_left/right, peak_left/right, finished
// cfg       to block   cfg_valid / cfg_ready cfg_index, cfg_data
//
// Write, restart, unused code and render of a finished voice: result in the next cycle.
// Render: one shared multiplier per channel steps through interpolation, envelope, three
// filter products and gain, and interpolation takes two reads on the single store read port.
// rst_n clears control state and loads register defaults; the store needs no clearing.
// Input stalls while a render runs or while an unaccepted result blocks the output register.
module sample_voice_render_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         operation,
    input  logic [15:0]        address,
    input  logic signed [15:0] sample_left,
    input  logic signed [15:0] sample_right,
    input  logic [15:0]        envelope,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [17:0] out_left,
    output logic signed [17:0] out_right,
    output logic [16:0]        peak_left,
    output logic [16:0]        peak_right,
    output logic               finished,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [23:0]        cfg_data
);

    svr_pkg::state_t state_reg, state_next;
    logic            out_valid_reg;

    logic        interp_reg;
    logic [23:0] pitch_reg;
    logic [16:0] length_reg;
    logic [15:0] gain_reg [2];
    logic        filt_en_reg;
    logic [15:0] cutoff_reg;
    logic [15:0] reson_reg;

    logic [31:0]        pos_reg;
    logic signed [23:0] bp_reg [2];
    logic signed [23:0] lp_reg [2];
    logic [16:0]        peak_reg [2];

    logic [31:0]        a_word_reg;
    logic [15:0]        env_reg;
    logic signed [17:0] x_reg [2];
    logic signed [24:0] diff_reg [2];
    logic signed [42:0] prod_reg [2];
    logic signed [17:0] out_reg [2];

    logic               in_accept;
    logic               start_render;
    logic               finished_c;
    logic               last_frame;
    logic               out_free;
    logic [16:0]        idx_next;
    logic [32:0]        pos_sum;
    logic [31:0]        pos_new;
    logic               wr_en;
    logic               rd_en;
    svr_pkg::addr_t     rd_addr;
    logic [31:0]        rd_data;
    logic signed [15:0] rd_half [2];
    logic signed [15:0] a_half [2];
    logic signed [24:0] mul_a [2];
    logic signed [17:0] mul_b [2];
    logic signed [42:0] product [2];
    logic signed [34:0] isum [2];
    logic signed [17:0] y_out [2];

    function automatic logic signed [23:0] sat24(input logic signed [42:0] v);
        if (v > 43'sd8388607)
            sat24 = 24'sh7FFFFF;
        else if (v < -43'sd8388608)
            sat24 = 24'sh800000;
        else
            sat24 = v[23:0];
    endfunction

    function automatic logic signed [17:0] sat18(input logic signed [42:0] v);
        if (v > 43'sd131071)
            sat18 = 18'sh1FFFF;
        else if (v < -43'sd131072)
            sat18 = 18'sh20000;
        else
            sat18 = v[17:0];
    endfunction

    assign in_accept    = in_valid && !in_stall;
    assign out_free     = !out_valid_reg || !out_stall;
    assign in_stall     = (state_reg != svr_pkg::S_IDLE) || (out_valid_reg && out_stall);
    assign finished_c   = (pos_reg == 32'hFFFF_FFFF) || ({1'b0, pos_reg[31:16]} >= length_reg);
    assign idx_next     = {1'b0, pos_reg[31:16]} + 17'd1;
    assign last_frame   = idx_next >= length_reg;
    assign start_render = in_accept && (operation == svr_pkg::OP_RENDER) && !finished_c;

    assign pos_sum = {1'b0, pos_reg} + {9'b0, pitch_reg};
    assign pos_new = pos_sum[32] ? 32'hFFFF_FFFF : pos_sum[31:0];

    assign wr_en   = in_accept && (operation == svr_pkg::OP_WRITE);
    assign rd_en   = start_render || (state_reg == svr_pkg::S_FETCH0);
    assign rd_addr = (state_reg == svr_pkg::S_FETCH0) ? svr_pkg::addr_t'(idx_next)
                                                      : svr_pkg::addr_t'(pos_reg[31:16]);

    svr_ram #(
        .WIDTH (32),
        .DEPTH (svr_pkg::SAMPLE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (svr_pkg::addr_t'(address)),
        .wr_data ({sample_right & svr_pkg::SAMPLE_MASK, sample_left & svr_pkg::SAMPLE_MASK}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // one multiplier per channel, operands picked by sequencer step
    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            rd_half[c] = $signed(rd_data[16*c +: 16]);
            a_half[c]  = $signed(a_word_reg[16*c +: 16]);
            isum[c]    = (35'(a_half[c]) <<< 16) + 35'(prod_reg[c]);
            y_out[c]   = sat18(prod_reg[c] >>> 12);
            unique case (state_reg)
                svr_pkg::S_FETCH1:
                begin
                    mul_a[c] = 25'(rd_half[c]) - 25'(a_half[c]);
                    mul_b[c] = $signed({2'b00, pos_reg[15:0]});
                end
                svr_pkg::S_ENV:
                begin
                    mul_a[c] = 25'(x_reg[c]);
                    mul_b[c] = $signed({2'b00, env_reg});
                end
                svr_pkg::S_FA:
                begin
                    mul_a[c] = 25'(bp_reg[c]);
                    mul_b[c] = $signed({2'b00, reson_reg});
                end
                svr_pkg::S_FB:
                begin
                    mul_a[c] = diff_reg[c];
                    mul_b[c] = $signed({2'b00, cutoff_reg});
                end
                svr_pkg::S_FD:
                begin
                    mul_a[c] = 25'(bp_reg[c]);
                    mul_b[c] = $signed({2'b00, cutoff_reg});
                end
                svr_pkg::S_GAIN:
                begin
                    mul_a[c] = filt_en_reg ? 25'(lp_reg[c]) : 25'(x_reg[c]);
                    mul_b[c] = $signed({2'b00, gain_reg[c]});
                end
                default:
                begin
                    mul_a[c] = '0;
                    mul_b[c] = '0;
                end
            endcase
            product[c] = mul_a[c] * mul_b[c];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            svr_pkg::S_IDLE:
            begin
                if (start_render)
                    state_next = svr_pkg::S_FETCH0;
            end
            svr_pkg::S_FETCH0:
            begin
                if (interp_reg && !last_frame)
                    state_next = svr_pkg::S_FETCH1;
                else
                    state_next = svr_pkg::S_ENV;
            end
            svr_pkg::S_FETCH1: state_next = svr_pkg::S_INTERP;
            svr_pkg::S_INTERP: state_next = svr_pkg::S_ENV;
            svr_pkg::S_ENV:    state_next = svr_pkg::S_ESC;
            svr_pkg::S_ESC:    state_next = filt_en_reg ? svr_pkg::S_FA : svr_pkg::S_GAIN;
            svr_pkg::S_FA:     state_next = svr_pkg::S_FB;
            svr_pkg::S_FB:     state_next = svr_pkg::S_FC;
            svr_pkg::S_FC:     state_next = svr_pkg::S_FD;
            svr_pkg::S_FD:     state_next = svr_pkg::S_FE;
            svr_pkg::S_FE:     state_next = svr_pkg::S_GAIN;
            svr_pkg::S_GAIN:   state_next = svr_pkg::S_OUT;
            svr_pkg::S_OUT:
            begin
                if (out_free)
                    state_next = svr_pkg::S_IDLE;
            end
            default:           state_next = svr_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= svr_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            interp_reg    <= 1'b0;
            pitch_reg     <= 24'd65536;
            length_reg    <= 17'd0;
            gain_reg[0]   <= 16'd4096;
            gain_reg[1]   <= 16'd4096;
            filt_en_reg   <= 1'b0;
            cutoff_reg    <= 16'd32768;
            reson_reg     <= 16'd0;
            pos_reg       <= '0;
            for (int c = 0; c < 2; c++)
            begin
                bp_reg[c]   <= '0;
                lp_reg[c]   <= '0;
                peak_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    svr_pkg::CFG_INTERPOLATE: interp_reg  <= cfg_data[0];
                    svr_pkg::CFG_PITCH_STEP:  pitch_reg   <= cfg_data;
                    svr_pkg::CFG_LENGTH:      length_reg  <= cfg_data[16:0];
                    svr_pkg::CFG_GAIN_LEFT:   gain_reg[0] <= cfg_data[15:0];
                    svr_pkg::CFG_GAIN_RIGHT:  gain_reg[1] <= cfg_data[15:0];
                    svr_pkg::CFG_FILTER_EN:   filt_en_reg <= cfg_data[0];
                    svr_pkg::CFG_CUTOFF:      cutoff_reg  <= cfg_data[15:0];
                    svr_pkg::CFG_RESONANCE:   reson_reg   <= cfg_data[15:0];
                    default: ;
                endcase
            end

            // everything but a live render raises out_valid in the cycle after it is accepted
            if (in_accept && !start_render)
                out_valid_reg <= 1'b1;
            else if ((state_reg == svr_pkg::S_OUT) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            if (in_accept && (operation == svr_pkg::OP_RESTART))
            begin
                pos_reg <= '0;
                for (int c = 0; c < 2; c++)
                begin
                    bp_reg[c]   <= '0;
                    lp_reg[c]   <= '0;
                    peak_reg[c] <= '0;
                end
            end

            for (int c = 0; c < 2; c++)
            begin
                if (state_reg == svr_pkg::S_FC)
                    bp_reg[c] <= sat24(prod_reg[c] >>> 15);
                if (state_reg == svr_pkg::S_FE)
                    lp_reg[c] <= sat24(43'(lp_reg[c]) + (prod_reg[c] >>> 15));
                if ((state_reg == svr_pkg::S_OUT) && out_free &&
                    (y_out[c] > $signed({1'b0, peak_reg[c]})))
                    peak_reg[c] <= y_out[c][16:0];
            end

            if ((state_reg == svr_pkg::S_OUT) && out_free)
                pos_reg <= pos_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_render)
            env_reg <= envelope;
        if (state_reg == svr_pkg::S_FETCH0)
            a_word_reg <= rd_data;
        for (int c = 0; c < 2; c++)
        begin
            unique case (state_reg) inside
                svr_pkg::S_IDLE:
                begin
                    if (in_accept && !start_render)
                        out_reg[c] <= '0;
                end
                svr_pkg::S_FETCH0:
                begin
                    // interpolating on the last frame gives silence
                    if (!interp_reg)
                        x_reg[c] <= 18'(rd_half[c]);
                    else if (last_frame)
                        x_reg[c] <= '0;
                end
                svr_pkg::S_INTERP: x_reg[c] <= 18'(isum[c] >>> 16);
                svr_pkg::S_ESC:    x_reg[c] <= 18'(prod_reg[c] >>> 15);
                svr_pkg::S_FA:
                begin
                    prod_reg[c] <= product[c];
                    diff_reg[c] <= 25'(x_reg[c]) - 25'(lp_reg[c]);
                end
                svr_pkg::S_FB:     prod_reg[c] <= prod_reg[c] + product[c];
                svr_pkg::S_FETCH1,
                svr_pkg::S_ENV,
                svr_pkg::S_FD,
                svr_pkg::S_GAIN:   prod_reg[c] <= product[c];
                svr_pkg::S_OUT:
                begin
                    if (out_free)
                        out_reg[c] <= y_out[c];
                end
                default: ;
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_left   = out_reg[0];
    assign out_right  = out_reg[1];
    assign peak_left  = peak_reg[0];
    assign peak_right = peak_reg[1];
    assign finished   = finished_c;
    assign cfg_ready  = 1'b1;

`ifndef ASSERT_OFF
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (operation == svr_pkg::OP_RESTART)
        |=> (pos_reg == 32'd0) && (peak_reg[0] == 17'd0) && (peak_reg[1] == 17'd0))
        else $error("restart did not clear voice state");

    a_finished_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (operation == svr_pkg::OP_RENDER) && finished_c
        |=> (pos_reg == $past(pos_reg)) && out_valid_reg && (out_reg[0] == 18'sd0))
        else $error("render of finished voice moved state or gave audio");

    a_render_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == svr_pkg::S_OUT) && out_free |=> out_valid_reg
        && (state_reg == svr_pkg::S_IDLE))
        else $error("render finished without a result beat");
`endif

endmodule
